### design/spat_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Session presence aging table package
// Shared sizes, state codes, result codes and controller/datapath bundles.
// ---------------------------------------------------------------------------
package spat_pkg;

    // Number of table entries and the widths that follow from it.
    localparam int SLOTS = 4;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Command codes carried by an input item.
    localparam logic CMD_MARK  = 1'b0;
    localparam logic CMD_SWEEP = 1'b1;

    // Machine select codes.
    localparam logic SEL_PATH = 1'b0;
    localparam logic SEL_RESV = 1'b1;

    // Per-entry presence machine.
    typedef enum logic [1:0] {
        MS_IDLE = 2'd0,
        MS_OLD  = 2'd1,
        MS_ACTV = 2'd2
    } t_mstate;

    // Result status codes.
    typedef enum logic [2:0] {
        RS_MATCH = 3'd0,
        RS_ADDED = 3'd1,
        RS_FULL  = 3'd2,
        RS_GONE  = 3'd3,
        RS_NONE  = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_FINISH
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_end;
        logic hit;
    } t_dp_stat;

endpackage

### design/spat_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Session presence aging table controller
// Sequences load, one scan step per used entry, and a closing step unless a mark matches.
// ---------------------------------------------------------------------------
module spat_ctrl
    import spat_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a match ends a mark scan early; the end of the used
    // entries leads to the closing step.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE: begin
                if (i_start) begin
                    n_state = CS_SCAN;
                end
            end
            CS_SCAN: begin
                if (i_stat.at_end) begin
                    n_state = CS_FINISH;
                end else if (i_stat.hit) begin
                    n_state = CS_IDLE;
                end
            end
            CS_FINISH: begin
                n_state = CS_IDLE;
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    // Outputs to the datapath and the busy flag.
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            CS_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            CS_SCAN: begin
                o_cmd.step = !i_stat.at_end;
            end
            CS_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

### design/spat_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Session presence aging table datapath
// Entry storage, key compare, aging and the registered result port.
// ---------------------------------------------------------------------------
module spat_dp
    import spat_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic        i_cmd_code,
    input  logic        i_machine_select,
    input  logic [31:0] i_dest_addr,
    input  logic [15:0] i_dest_port,
    output t_dp_stat    o_stat,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [1:0]  o_slot_index,
    output logic [31:0] o_gone_addr,
    output logic [15:0] o_gone_port,
    output logic        o_last
);

    // Table entries.
    logic [31:0] r_addr [SLOTS];
    logic [15:0] r_port [SLOTS];
    t_mstate     r_path [SLOTS];
    t_mstate     r_resv [SLOTS];
    logic [CNT_W-1:0] r_used;

    // Item being worked on.
    logic             r_cmd;
    logic             r_sel;
    logic [31:0]      r_key_addr;
    logic [15:0]      r_key_port;
    logic [CNT_W-1:0] r_idx;

    // Free entry found during a mark scan.
    logic             r_have_free;
    logic [IDX_W-1:0] r_free;

    // Gone entry held back until it is known whether another follows.
    logic             r_pend_valid;
    logic [IDX_W-1:0] r_pend_idx;
    logic [31:0]      r_pend_addr;
    logic [15:0]      r_pend_port;

    // Result register.
    logic             r_out_valid;
    t_status          r_out_status;
    logic [IDX_W-1:0] r_out_slot;
    logic [31:0]      r_out_addr;
    logic [15:0]      r_out_port;
    logic             r_out_last;

    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] used_idx;
    t_mstate          cur_sel;
    logic             cur_both_idle;
    logic             key_eq;
    logic             at_end;

    // Current entry under the scan pointer.
    assign idx           = r_idx[IDX_W-1:0];
    assign used_idx      = r_used[IDX_W-1:0];
    assign cur_sel       = (r_sel == SEL_RESV) ? r_resv[idx] : r_path[idx];
    assign cur_both_idle = (r_path[idx] == MS_IDLE) && (r_resv[idx] == MS_IDLE);
    assign key_eq        = (r_addr[idx] == r_key_addr) && (r_port[idx] == r_key_port);
    assign at_end        = (r_idx == r_used);

    assign o_stat.at_end = at_end;
    assign o_stat.hit    = (r_cmd == CMD_MARK) && !at_end && (cur_sel != MS_IDLE) && key_eq;

    // Table update, scan bookkeeping and result generation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_addr[k] <= '0;
                r_port[k] <= '0;
                r_path[k] <= MS_IDLE;
                r_resv[k] <= MS_IDLE;
            end
            r_used       <= '0;
            r_idx        <= '0;
            r_have_free  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;

            // Capture a new item and rewind the scan.
            if (i_cmd.load) begin
                r_cmd        <= i_cmd_code;
                r_sel        <= i_machine_select;
                r_key_addr   <= i_dest_addr;
                r_key_port   <= i_dest_port;
                r_idx        <= '0;
                r_have_free  <= 1'b0;
                r_pend_valid <= 1'b0;
            end

            // One entry per cycle.
            if (i_cmd.step) begin
                r_idx <= r_idx + 1'b1;
                if (r_cmd == CMD_MARK) begin
                    if (cur_sel == MS_IDLE) begin
                        if (cur_both_idle) begin
                            r_addr[idx] <= '0;
                            r_port[idx] <= '0;
                            r_have_free <= 1'b1;
                            r_free      <= idx;
                        end
                    end else if (key_eq) begin
                        if (r_sel == SEL_RESV) begin
                            r_resv[idx] <= MS_ACTV;
                        end else begin
                            r_path[idx] <= MS_ACTV;
                        end
                        r_out_valid  <= 1'b1;
                        r_out_status <= RS_MATCH;
                        r_out_slot   <= idx;
                        r_out_addr   <= '0;
                        r_out_port   <= '0;
                        r_out_last   <= 1'b1;
                    end
                end else begin
                    case (cur_sel)
                        MS_OLD: begin
                            if (r_sel == SEL_RESV) begin
                                r_resv[idx] <= MS_IDLE;
                            end else begin
                                r_path[idx] <= MS_IDLE;
                            end
                            // The earlier gone entry is not the last one.
                            if (r_pend_valid) begin
                                r_out_valid  <= 1'b1;
                                r_out_status <= RS_GONE;
                                r_out_slot   <= r_pend_idx;
                                r_out_addr   <= r_pend_addr;
                                r_out_port   <= r_pend_port;
                                r_out_last   <= 1'b0;
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_idx   <= idx;
                            r_pend_addr  <= r_addr[idx];
                            r_pend_port  <= r_port[idx];
                        end
                        MS_ACTV: begin
                            if (r_sel == SEL_RESV) begin
                                r_resv[idx] <= MS_OLD;
                            end else begin
                                r_path[idx] <= MS_OLD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Closing step after the scan has passed every used entry.
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                r_out_last  <= 1'b1;
                r_out_addr  <= '0;
                r_out_port  <= '0;
                if (r_cmd == CMD_MARK) begin
                    if (r_have_free) begin
                        r_addr[r_free] <= r_key_addr;
                        r_port[r_free] <= r_key_port;
                        if (r_sel == SEL_RESV) begin
                            r_resv[r_free] <= MS_ACTV;
                        end else begin
                            r_path[r_free] <= MS_ACTV;
                        end
                        r_out_status <= RS_ADDED;
                        r_out_slot   <= r_free;
                    end else if (r_used >= CNT_W'(SLOTS)) begin
                        r_out_status <= RS_FULL;
                        r_out_slot   <= '0;
                    end else begin
                        r_addr[used_idx] <= r_key_addr;
                        r_port[used_idx] <= r_key_port;
                        if (r_sel == SEL_RESV) begin
                            r_resv[used_idx] <= MS_ACTV;
                        end else begin
                            r_path[used_idx] <= MS_ACTV;
                        end
                        r_used       <= r_used + 1'b1;
                        r_out_status <= RS_ADDED;
                        r_out_slot   <= used_idx;
                    end
                end else begin
                    if (r_pend_valid) begin
                        r_out_status <= RS_GONE;
                        r_out_slot   <= r_pend_idx;
                        r_out_addr   <= r_pend_addr;
                        r_out_port   <= r_pend_port;
                    end else begin
                        r_out_status <= RS_NONE;
                        r_out_slot   <= '0;
                    end
                    r_pend_valid <= 1'b0;
                end
            end
        end
    end

    // Result ports.
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot_index = 2'(r_out_slot);
    assign o_gone_addr  = r_out_addr;
    assign o_gone_port  = r_out_port;
    assign o_last       = r_out_last;

endmodule

### design/session_presence_aging_table_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Session presence aging table
// Four-entry session table with path and reservation presence aging.
// ---------------------------------------------------------------------------
// Usage:
//   An item (command, machine select, address, port) is taken on a rising
//   edge where start is high and busy is low. Busy stays high while the item
//   is worked on. Results appear on the o_ ports for one cycle each, marked
//   by o_valid; o_last flags the final result of an item. The receiver
//   cannot stall the block: every result must be taken as it is shown.
//   Timing: the controller scans one used entry per cycle. A mark with no
//   match scans every used entry (up to four) and then takes the closing
//   step; a mark that matches at entry i ends its scan at that entry, with
//   no closing step. Either way its single result is shown in the first
//   cycle that busy is low. A sweep scans every used entry, takes the
//   closing step and gives one result per entry gone, each held back until
//   the next gone entry or the closing step so that the last can be flagged,
//   or a single "none gone" result. No new item is taken while busy is high.
//   Reset (synchronous, active low) empties the table and returns every
//   presence machine to idle; no item is pending afterwards.
// ---------------------------------------------------------------------------
module session_presence_aging_table_top
    import spat_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic        i_machine_select,
    input  logic [31:0] i_dest_addr,
    input  logic [15:0] i_dest_port,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [1:0]  o_slot_index,
    output logic [31:0] o_gone_addr,
    output logic [15:0] o_gone_port,
    output logic        o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer.
    spat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    // Table and result datapath.
    spat_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_cmd_code       (i_cmd),
        .i_machine_select (i_machine_select),
        .i_dest_addr      (i_dest_addr),
        .i_dest_port      (i_dest_port),
        .o_stat           (dp_stat),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_slot_index     (o_slot_index),
        .o_gone_addr      (o_gone_addr),
        .o_gone_port      (o_gone_port),
        .o_last           (o_last)
    );

    // An accepted item keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    // Only gone reports can be followed by further results of the same item.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != RS_GONE)) |-> o_last)
        else $error("non-gone result without last marker");

    // A result that is not last means the item is still being worked on.
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("block idle with results still owed");

    // A sweep with nothing gone reports zero fields.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == RS_NONE)) |->
            ((o_slot_index == 2'd0) && (o_gone_addr == 32'd0) && (o_gone_port == 16'd0)))
        else $error("none-gone result carries data");

endmodule

### dv/tb_session_presence_aging_table_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the session presence aging table
// Drives mark and sweep items through the start/busy handshake and keeps its
// own copy of the four-entry table with both presence machines. Every
// strobed result is checked field by field against the oldest predicted
// report. The run covers the empty table, filling and overflow, keys live in
// only one machine, aging down to gone reports, reuse of fully idle entries,
// and a long stretch of random traffic over a small pool of keys.
// ---------------------------------------------------------------------------
module tb_session_presence_aging_table_top
    import spat_pkg::*;
();

    // One predicted result of the table.
    typedef struct {
        t_status     status;
        logic [1:0]  slot;
        logic [31:0] addr;
        logic [15:0] port;
        logic        last;
    } t_report;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cmd;
    logic        i_machine_select;
    logic [31:0] i_dest_addr;
    logic [15:0] i_dest_port;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [1:0]  o_slot_index;
    logic [31:0] o_gone_addr;
    logic [15:0] o_gone_port;
    logic        o_last;

    // Shadow copy of the table: keys, one presence machine per select value.
    logic [31:0] shadow_addr [SLOTS];
    logic [15:0] shadow_port [SLOTS];
    t_mstate     shadow_state [2][SLOTS];
    int          shadow_used;

    t_report     due_reports[$];
    logic [31:0] key_addr_pool [6];
    logic [15:0] key_port_pool [6];
    bit          allow_gaps;
    int          fault_count;
    int          mark_count, sweep_count, added_count, matched_count;
    int          full_count, gone_count;

    session_presence_aging_table_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_machine_select (i_machine_select),
        .i_dest_addr      (i_dest_addr),
        .i_dest_port      (i_dest_port),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_slot_index     (o_slot_index),
        .o_gone_addr      (o_gone_addr),
        .o_gone_port      (o_gone_port),
        .o_last           (o_last)
    );

    // Clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the length of the run.
    initial begin
        #200000;
        $display("FAIL session_presence_aging_table_top");
        $finish;
    end

    // Counts a failure and reports only the first ten in full.
    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Works out the reports that one accepted item causes and updates the
    // shadow table in the same way as the block.
    task automatic predict_table_op(input logic cmd, input logic sel,
                                    input logic [31:0] addr,
                                    input logic [15:0] port);
        t_report batch[$];
        t_report r;
        int      n;
        int      free_slot;
        bit      have_free;
        bit      matched;

        n         = shadow_used;
        free_slot = 0;
        have_free = 1'b0;
        matched   = 1'b0;
        r.addr    = '0;
        r.port    = '0;
        r.last    = 1'b1;
        r.slot    = '0;
        if (cmd == CMD_MARK) begin
            mark_count++;
            for (int i = 0; i < n; i++) begin
                if (shadow_state[sel][i] == MS_IDLE) begin
                    // A fully idle entry loses its key and becomes a candidate.
                    if (shadow_state[0][i] == MS_IDLE && shadow_state[1][i] == MS_IDLE) begin
                        shadow_addr[i] = '0;
                        shadow_port[i] = '0;
                        have_free      = 1'b1;
                        free_slot      = i;
                    end
                    continue;
                end
                if (shadow_addr[i] == addr && shadow_port[i] == port) begin
                    shadow_state[sel][i] = MS_ACTV;
                    r.status = RS_MATCH;
                    r.slot   = i[1:0];
                    matched  = 1'b1;
                    matched_count++;
                    break;
                end
            end
            if (!matched) begin
                if (!have_free && n >= SLOTS) begin
                    r.status = RS_FULL;
                    full_count++;
                end else begin
                    if (!have_free) begin
                        free_slot   = n;
                        shadow_used = n + 1;
                    end
                    shadow_addr[free_slot]       = addr;
                    shadow_port[free_slot]       = port;
                    shadow_state[sel][free_slot] = MS_ACTV;
                    r.status = RS_ADDED;
                    r.slot   = free_slot[1:0];
                    added_count++;
                end
            end
            batch.push_back(r);
        end else begin
            sweep_count++;
            // Active entries age to old; old entries go idle and are reported.
            for (int i = 0; i < n; i++) begin
                if (shadow_state[sel][i] == MS_OLD) begin
                    shadow_state[sel][i] = MS_IDLE;
                    r.status = RS_GONE;
                    r.slot   = i[1:0];
                    r.addr   = shadow_addr[i];
                    r.port   = shadow_port[i];
                    r.last   = 1'b0;
                    batch.push_back(r);
                    gone_count++;
                end else if (shadow_state[sel][i] == MS_ACTV) begin
                    shadow_state[sel][i] = MS_OLD;
                end
            end
            if (batch.size() == 0) begin
                r.status = RS_NONE;
                r.last   = 1'b1;
                batch.push_back(r);
            end else begin
                batch[batch.size() - 1].last = 1'b1;
            end
        end
        foreach (batch[k]) due_reports.push_back(batch[k]);
    endtask

    // Sends one item and waits for the block to take it; may then idle.
    task automatic issue_item(input logic cmd, input logic sel,
                              input logic [31:0] addr, input logic [15:0] port);
        int gap;

        start            <= 1'b1;
        i_cmd            <= cmd;
        i_machine_select <= sel;
        i_dest_addr      <= addr;
        i_dest_port      <= port;
        do @(posedge i_clk); while (busy);
        predict_table_op(cmd, sel, addr, port);
        if (allow_gaps && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Result checker: every strobed result against the oldest prediction.
    always @(posedge i_clk) begin
        t_report want;

        if (i_rst_n && o_valid) begin
            if (due_reports.size() == 0) begin
                note_fault($sformatf("unexpected result status %0d slot %0d",
                                     o_status, o_slot_index));
            end else begin
                want = due_reports.pop_front();
                if (o_status !== want.status || o_slot_index !== want.slot ||
                    o_gone_addr !== want.addr || o_gone_port !== want.port ||
                    o_last !== want.last) begin
                    note_fault($sformatf({"expected st %0d slot %0d addr %h port %h ",
                                          "last %0b, got st %0d slot %0d addr %h ",
                                          "port %h last %0b"},
                        want.status, want.slot, want.addr, want.port, want.last,
                        o_status, o_slot_index, o_gone_addr, o_gone_port, o_last));
                end
            end
        end
    end

    // Sweeps on the empty table report nothing gone for both machines.
    task automatic test_empty_sweep();
        issue_item(CMD_SWEEP, SEL_PATH, 32'hFFFF_FFFF, 16'hFFFF);
        issue_item(CMD_SWEEP, SEL_RESV, 32'h0000_0000, 16'h0000);
    endtask

    // Fills the table, including a key live in one machine only, then
    // overflows it and matches an existing key.
    task automatic test_fill_and_overflow();
        issue_item(CMD_MARK, SEL_PATH, 32'h0000_0000, 16'h0000);
        issue_item(CMD_MARK, SEL_RESV, 32'h0000_0000, 16'h0000);
        issue_item(CMD_MARK, SEL_PATH, 32'hFFFF_FFFF, 16'hFFFF);
        issue_item(CMD_MARK, SEL_RESV, 32'hA5A5_5A5A, 16'h1234);
        issue_item(CMD_MARK, SEL_PATH, 32'h1234_5678, 16'hFEDC);
        issue_item(CMD_MARK, SEL_RESV, 32'hA5A5_5A5A, 16'h1235);
        issue_item(CMD_MARK, SEL_PATH, 32'h0000_0000, 16'h0000);
        issue_item(CMD_MARK, SEL_RESV, 32'hA5A5_5A5A, 16'h1234);
        issue_item(CMD_MARK, SEL_PATH, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    // Ages both machines down to gone reports and reuses freed entries.
    task automatic test_aging_and_reuse();
        issue_item(CMD_SWEEP, SEL_PATH, 32'h0, 16'h0);
        issue_item(CMD_SWEEP, SEL_PATH, 32'h0, 16'h0);
        issue_item(CMD_SWEEP, SEL_PATH, 32'h0, 16'h0);
        issue_item(CMD_MARK, SEL_RESV, 32'h5555_AAAA, 16'h8001);
        issue_item(CMD_SWEEP, SEL_RESV, 32'h0, 16'h0);
        issue_item(CMD_SWEEP, SEL_RESV, 32'h0, 16'h0);
        issue_item(CMD_MARK, SEL_PATH, 32'h0F0F_F0F0, 16'h7FFE);
        issue_item(CMD_MARK, SEL_PATH, 32'hFFFF_FFFF, 16'hFFFF);
        issue_item(CMD_MARK, SEL_RESV, 32'h0000_0001, 16'h0001);
        issue_item(CMD_MARK, SEL_PATH, 32'h8000_0000, 16'h8000);
        issue_item(CMD_SWEEP, SEL_RESV, 32'h0, 16'h0);
    endtask

    // Random traffic, mostly marks over a small pool of keys so that
    // matches, overflow and aging all happen, with sweeps mixed in.
    task automatic test_random_traffic(input int count, input bit gaps);
        int          pick;
        int          k;
        logic        sel;
        logic [31:0] addr;
        logic [15:0] port;

        allow_gaps = gaps;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, 5);
            sel  = 1'($urandom_range(0, 1));
            addr = key_addr_pool[k];
            port = key_port_pool[k];
            if (pick < 28) begin
                issue_item(CMD_SWEEP, sel, $urandom, 16'($urandom));
            end else begin
                if (pick >= 93) begin
                    addr = $urandom;
                    port = 16'($urandom);
                end else if (pick >= 85) begin
                    port = 16'($urandom);
                end
                issue_item(CMD_MARK, sel, addr, port);
            end
        end
    endtask

    // Main sequence: reset, directed tests, random traffic, drain.
    initial begin
        int waited;

        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_cmd            = CMD_MARK;
        i_machine_select = SEL_PATH;
        i_dest_addr      = '0;
        i_dest_port      = '0;
        allow_gaps       = 1'b1;
        fault_count      = 0;
        mark_count       = 0;
        sweep_count      = 0;
        added_count      = 0;
        matched_count    = 0;
        full_count       = 0;
        gone_count       = 0;
        shadow_used      = 0;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_addr[i]     = '0;
            shadow_port[i]     = '0;
            shadow_state[0][i] = MS_IDLE;
            shadow_state[1][i] = MS_IDLE;
        end
        key_addr_pool[0] = 32'h0000_0000;
        key_port_pool[0] = 16'h0000;
        key_addr_pool[1] = 32'hFFFF_FFFF;
        key_port_pool[1] = 16'hFFFF;
        for (int i = 2; i < 6; i++) begin
            key_addr_pool[i] = $urandom;
            key_port_pool[i] = 16'($urandom);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_sweep();
        test_fill_and_overflow();
        test_aging_and_reuse();
        test_random_traffic(110, 1'b1);
        test_random_traffic(40, 1'b0);
        start <= 1'b0;

        // Wait for outstanding reports, then watch for stray results.
        waited = 0;
        while (due_reports.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (16) @(posedge i_clk);
        if (due_reports.size() != 0) begin
            note_fault($sformatf("%0d predicted results never arrived",
                                 due_reports.size()));
        end

        $display("Ran %0d marks (%0d added, %0d matched, %0d full) and %0d sweeps",
                 mark_count, added_count, matched_count, full_count, sweep_count);
        $display("with %0d gone reports; %0d mismatches", gone_count, fault_count);
        if (fault_count == 0) begin
            $display("PASS session_presence_aging_table_top");
        end else begin
            $display("FAIL session_presence_aging_table_top");
        end
        $finish;
    end

endmodule

### sim.f
design/spat_pkg.sv
design/spat_ctrl.sv
design/spat_dp.sv
design/session_presence_aging_table_top.sv
dv/tb_session_presence_aging_table_top.sv
